FILE: hdl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types and constants of the trial-division prime factoriser.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int NumberBits = 31;
    localparam int MaxResults = 30;
    localparam int KW         = $clog2(MaxResults);

    localparam logic [1:0] ST_PRIME   = 2'd0;
    localparam logic [1:0] ST_FACTOR  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [1:0] {
        E_INVALID,
        E_FINAL,
        E_FACTOR,
        E_CAP
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  advance;
        logic  take_factor;
        logic  emit;
        t_emit kind;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic sq_gt_r;
        logic div_done;
        logic rem_zero;
        logic k_cap;
    } t_sts;

endpackage

FILE: hdl/pf_ctrl.sv
// ----------------------------------------------------------------------------
// pf_ctrl
// Sequencer: steps candidates, starts divisions and issues results.
// ----------------------------------------------------------------------------
module pf_ctrl
    import pf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.lt2) begin
                    if (out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = E_INVALID;
                        n_state  = S_IDLE;
                    end
                end else if (i_sts.sq_gt_r) begin
                    if (out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = E_FINAL;
                        n_state  = S_IDLE;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        cmd.advance = 1'b1;
                        n_state     = S_CHECK;
                    end else if (out_free) begin
                        cmd.emit = 1'b1;
                        if (i_sts.k_cap) begin
                            cmd.kind = E_CAP;
                            n_state  = S_IDLE;
                        end else begin
                            cmd.kind        = E_FACTOR;
                            cmd.take_factor = 1'b1;
                            n_state         = S_CHECK;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_valid;
    assign o_stall = (r_state != S_IDLE);

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free) else $error("result issued over a held result");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == S_CHECK)) else $error("request not taken to check");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid) else $error("stalled result dropped");

endmodule

FILE: hdl/pf_dpath.sv
// ----------------------------------------------------------------------------
// pf_dpath
// Remainder, candidate and square registers, bit-serial divider, result regs.
// ----------------------------------------------------------------------------
module pf_dpath
    import pf_pkg::*;
#(
    parameter int W = NumberBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_value_in,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    output logic [W-1:0] o_factor,
    output logic [1:0]   o_status,
    output logic         o_last
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_n, r_r, r_d, r_quo, r_rem;
    logic [W:0]    r_sq;
    logic [2:0]    r_stp;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_factor;
    logic [1:0]    r_status;
    logic          r_last;

    logic [W:0]    trial;
    logic          ge;
    logic [W:0]    t_lin;
    logic [W+2:0]  t_inc;
    logic [W-1:0]  n_d;
    logic [2:0]    n_stp;

    assign trial = {r_rem, r_quo[W-1]};
    assign ge    = (trial >= {1'b0, r_d});

    // (d + s)^2 = d^2 + (2d + s) * s, with s a power of two
    assign t_lin = {r_d, 1'b0} + {{(W-2){1'b0}}, r_stp};
    always_comb begin
        case (r_stp)
            3'd1:    t_inc = {2'b00, t_lin};
            3'd2:    t_inc = {1'b0, t_lin, 1'b0};
            default: t_inc = {t_lin, 2'b00};
        endcase
    end
    assign n_d   = r_d + {{(W-3){1'b0}}, r_stp};
    assign n_stp = ((r_d == W'(2)) || (r_d == W'(3))) ? 3'd2
                 : ((r_stp == 3'd2) ? 3'd4 : 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_value_in;
            r_r   <= i_value_in;
            r_d   <= W'(2);
            r_sq  <= (W + 1)'(4);
            r_stp <= 3'd1;
            r_k   <= '0;
        end
        if (i_cmd.advance) begin
            r_d   <= n_d;
            r_sq  <= r_sq + t_inc[W:0];
            r_stp <= n_stp;
        end
        if (i_cmd.take_factor) begin
            r_r <= r_quo;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_r;
        end else if (r_cnt != '0) begin
            // shift one dividend bit in, subtract where it fits
            r_rem <= ge ? W'(trial - {1'b0, r_d}) : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                E_INVALID: begin
                    r_factor <= r_n;
                    r_status <= ST_INVALID;
                    r_last   <= 1'b1;
                end
                E_FINAL: begin
                    r_factor <= r_r;
                    r_status <= (r_k == '0) ? ST_PRIME : ST_FACTOR;
                    r_last   <= 1'b1;
                end
                E_FACTOR: begin
                    r_factor <= r_d;
                    r_status <= ST_FACTOR;
                    r_last   <= 1'b0;
                end
                default: begin
                    r_factor <= r_r;
                    r_status <= ST_FACTOR;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_sts.lt2      = (r_n < W'(2));
    assign o_sts.sq_gt_r  = (r_sq > {1'b0, r_r});
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.k_cap    = (r_k == KW'(MaxResults - 1));

    assign o_factor = r_factor;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

FILE: hdl/prime_factorizer.sv
// Each candidate tried or factor removed costs one full bit-serial division;
// a W-bit prime needs about sqrt(n)/3 candidates.
// One request at a time: o_stall stays high until the request is done; the
// bit-serial divider (one quotient bit per cycle) dominates the run time.
// Reset: synchronous, active low; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// prime_factorizer
// Trial-division classifier: issues a prime, its prime factors or invalid.
// ----------------------------------------------------------------------------
module prime_factorizer
    import pf_pkg::*;
#(
    parameter int NUMBER_BITS = NumberBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [NUMBER_BITS-1:0] i_value_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [NUMBER_BITS-1:0] o_factor,
    output logic [1:0]             o_status,
    output logic                   o_last
);

    t_cmd cmd;
    t_sts sts;

    pf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pf_dpath #(.W(NUMBER_BITS)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value_in (i_value_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_factor   (o_factor),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

FILE: bench/pf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pf_checker
// Watches both channels of the factoriser, predicts each result list by trial
// division and compares every result field by field, oldest first.
// ----------------------------------------------------------------------------
module pf_checker
    import pf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall_in,
    input  logic [NumberBits-1:0] i_value_in,
    input  logic                  i_out_valid,
    input  logic                  i_stall_out,
    input  logic [NumberBits-1:0] i_factor,
    input  logic [1:0]            i_status,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [NumberBits-1:0] factor;
        logic [1:0]            status;
        logic                  last;
    } t_result;

    t_result factor_queue[$];

    function automatic logic is_prime(longint unsigned n);
        longint unsigned d;
        if (n <= 1) return 1'b0;
        if (n <= 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        for (d = 5; d <= n / d; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_factors(input logic [NumberBits-1:0] value);
        longint unsigned n, r, d;
        int k;
        t_result res;
        n = value;
        k = 0;
        if (n < 2) begin
            factor_queue.push_back('{value, ST_INVALID, 1'b1});
        end else if (is_prime(n)) begin
            factor_queue.push_back('{value, ST_PRIME, 1'b1});
        end else begin
            r = n;
            d = 2;
            while (d <= r / d) begin
                while (r % d == 0) begin
                    if (k == MaxResults - 1) begin
                        factor_queue.push_back('{r[NumberBits-1:0], ST_FACTOR, 1'b1});
                        return;
                    end
                    factor_queue.push_back('{d[NumberBits-1:0], ST_FACTOR, 1'b0});
                    k++;
                    r = r / d;
                end
                if (d == 2) d = 3;
                else if (d == 3) d = 5;
                else if (d % 6 == 5) d = d + 2;
                else d = d + 4;
            end
            if (r > 1) begin
                factor_queue.push_back('{r[NumberBits-1:0], ST_FACTOR, 1'b1});
            end else begin
                res = factor_queue.pop_back();
                res.last = 1'b1;
                factor_queue.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) predict_factors(i_value_in);
            if (i_out_valid && !i_stall_out) begin
                if (factor_queue.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result: factor %0d status %0d last %0d",
                                 i_factor, i_status, i_last);
                end else begin
                    want = factor_queue.pop_front();
                    if (want.factor !== i_factor || want.status !== i_status
                            || want.last !== i_last) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.factor, want.status, want.last,
                                     i_factor, i_status, i_last);
                    end
                end
            end
        end
        o_pending <= factor_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

FILE: bench/tb_prime_factorizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prime_factorizer
// Drives directed and random values through the factoriser under several
// idling patterns; the checker predicts and compares the factor lists.
// ----------------------------------------------------------------------------
module tb_prime_factorizer;
    import pf_pkg::*;

    localparam int Limit = 300_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [NumberBits-1:0] i_value_in;
    logic                  o_valid;
    logic                  i_stall;
    logic [NumberBits-1:0] o_factor;
    logic [1:0]            o_status;
    logic                  o_last;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct;
    int                    stall_pct;
    int                    hold_cycles;
    int                    cycle_count = 0;
    logic                  hold_req;

    prime_factorizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_value_in(i_value_in), .o_valid(o_valid), .i_stall(i_stall),
        .o_factor(o_factor), .o_status(o_status), .o_last(o_last)
    );

    pf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_value_in(i_value_in), .i_out_valid(o_valid), .i_stall_out(i_stall),
        .i_factor(o_factor), .i_status(o_status), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            i_stall     <= 1'b0;
        end else if (hold_req) begin
            hold_cycles <= 400;
            i_stall     <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > Limit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [NumberBits-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value_in <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // mostly small values keep trial division quick; a few go large
    function automatic logic [NumberBits-1:0] random_value();
        int pick;
        logic [NumberBits-1:0] v;
        pick = $urandom_range(99);
        if (pick < 50) v = $urandom_range(5000);
        else if (pick < 70) v = $urandom_range(1 << 20);
        else if (pick < 85) v = (1 << $urandom_range(30)) * (1 + $urandom_range(1));
        else if (pick < 95) v = $urandom_range(20) * $urandom_range(50) * $urandom_range(9);
        else v = $urandom;
        return v;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_valid) @(posedge i_clk);
    endtask

    initial begin
        logic [NumberBits-1:0] directed_values[$];
        int wait_count;
        directed_values = '{0, 1, 2, 3, 4, 5, 6, 25, 35, 49, 97, 121,
                            31'h4000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFE,
                            2147483629, 46349 * 46349, 65536 * 3, (1 << 30) - 1,
                            30030, 510510, 1234567, 999983, 31'h5555_5555};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value_in = '0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[i]) send_request(directed_values[i]);
        drain();

        // hold the receiver off while requests keep coming
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (8) send_request($urandom_range(200));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 72; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 72; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            repeat (25) send_request(random_value());
            // pause until every expected result has come
            drain();
        end
        stall_pct = 0;
        drain();

        wait_count = 0;
        while (wait_count < 200) begin
            @(posedge i_clk);
            wait_count++;
        end
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/pf_pkg.sv
hdl/pf_ctrl.sv
hdl/pf_dpath.sv
hdl/prime_factorizer.sv
bench/pf_checker.sv
bench/tb_prime_factorizer.sv
